@@ hdl/dcms_pkg.sv @@
// Shared constants, configuration register indexes and fixed-point helpers of the F/G stencil.
package dcms_pkg;

    localparam int MAX_COLS = 1024;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = 11;
    localparam int CFG_W    = 3;

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_COLS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = {ROW_W{1'b1}};

    typedef enum logic [CFG_W-1:0] {
        REG_DT     = 3'd0,
        REG_ALPHA  = 3'd1,
        REG_INV_DX = 3'd2,
        REG_INV_DY = 3'd3,
        REG_INV_RE = 3'd4,
        REG_GX     = 3'd5,
        REG_GY     = 3'd6
    } t_cfg_reg;

    localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] y;
        if (x > SAT_HI) begin
            y = 32'sh7FFF_FFFF;
        end else if (x < SAT_LO) begin
            y = 32'sh8000_0000;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

    function automatic logic signed [63:0] sx(input logic signed [31:0] x);
        return {{32{x[31]}}, x};
    endfunction

endpackage

@@ hdl/dcms_mulq.sv @@
// Shared saturating 32x32 signed multiplier with a registered 64-bit product.
module dcms_mulq
    import dcms_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic signed [63:0] o_prod
);

    logic signed [31:0] a_sat;
    logic signed [31:0] b_sat;

    assign a_sat = sat32(i_a);
    assign b_sat = sat32(i_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_prod <= 64'(a_sat * b_sat);
        end
    end

endmodule

@@ hdl/donor_cell_momentum_stencil.sv @@
// Top level of the donor-cell F/G momentum stencil on a staggered grid.
// Cells (u, v) enter on the slave stream in raster order, one frame of rows
// 0..imax+1 and columns 0..jmax+1; tlast marks the last column of a row and
// tuser marks every cell of the last row. For each cell with row and column
// of at least one, the master stream carries one word with F and G of the
// cell one row and one column behind, their valid flags in tuser and tlast
// on the last interior cell of the frame. The cfg channel is always ready; the
// user must send configuration words only while idle, which is not enforced.
// The slave stream is ready only in the idle state; a word that gives no result
// goes back to idle from the READ state. Otherwise all products go through one
// shared multiplier. Two line memories hold rows r-1 and r-2, read on accept
// and written back in the next cycle.
// Reset restores the register defaults, clears the counters and the window
// and empties the output register; the line memories are not cleared.
// A stalled receiver holds the result in the output register; the next input
// word is still accepted and computed, and waits only to hand over its result.
module donor_cell_momentum_stencil
    import dcms_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [63:0]      i_s_tdata,   // u [31:0], v [63:32]
    input  logic             i_s_tlast,   // end_of_row
    input  logic             i_s_tuser,   // in_last_row
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [63:0]      o_m_tdata,   // f_value [31:0], g_value [63:32]
    output logic             o_m_tlast,   // frame_done
    output logic [1:0]       o_m_tuser,   // f_valid [0], g_valid [1]
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_index,
    input  logic [31:0]      i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_IXX, S_IYY, S_PART, S_LAPX, S_LAPY, S_LAPR,
        S_TERM, S_CONV, S_FIN, S_EMIT
    } t_state;

    logic [63:0] mem_row1 [MAX_COLS];
    logic [63:0] mem_row2 [MAX_COLS];

    t_state r_state;
    logic   r_ph, r_which, r_term;
    logic [2:0] r_sub;

    logic [30:0]        r_dt, r_inv_dx, r_inv_dy, r_inv_re;
    logic [16:0]        r_alpha;
    logic signed [31:0] r_gx, r_gy;

    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    logic [63:0]        r_rd1, r_rd2;
    logic signed [31:0] r_u_in, r_v_in;
    logic               r_eor, r_last;

    logic signed [31:0] r_wl_u1, r_wl_v1, r_wl_v2;
    logic signed [31:0] r_wc_u [3];
    logic signed [31:0] r_wc_v [3];

    logic r_f_ok, r_g_ok, r_row_edge, r_col_edge, r_done;

    logic signed [63:0] r_ixx, r_iyy, r_lap, r_sum, r_acc, r_tmp;
    logic signed [63:0] r_s1, r_t1, r_d1, r_s2, r_t2, r_d2, r_inv;
    logic signed [31:0] r_f, r_g;

    logic               r_out_valid;
    logic signed [31:0] r_out_f, r_out_g;
    logic               r_out_fv, r_out_gv, r_out_done;

    logic signed [63:0] u_c, u_n, u_s, u_w, u_e, u_ne;
    logic signed [63:0] v_c, v_n, v_s, v_w, v_e, v_sw;
    logic signed [63:0] n_s1, n_t1, n_d1, n_s2, n_t2, n_d2, n_inv;
    logic signed [63:0] op_a, op_b, prod, q, g_sel, c_sel;
    logic               mul_en, s_acc, out_free;

    assign u_c  = sx(r_wc_u[1]);
    assign u_n  = sx(r_wc_u[0]);
    assign u_s  = sx(r_wc_u[2]);
    assign u_w  = sx(r_wl_u1);
    assign u_e  = sx(r_rd1[31:0]);
    assign u_ne = sx(r_rd2[31:0]);
    assign v_c  = sx(r_wc_v[1]);
    assign v_n  = sx(r_wc_v[0]);
    assign v_s  = sx(r_wc_v[2]);
    assign v_w  = sx(r_wl_v1);
    assign v_e  = sx(r_rd1[63:32]);
    assign v_sw = sx(r_wl_v2);

    assign g_sel = r_which ? sx(r_gy) : sx(r_gx);
    assign c_sel = r_which ? v_c : u_c;
    assign q     = prod >>> 16;

    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free   = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_g, r_out_f};
    assign o_m_tuser  = {r_out_gv, r_out_fv};
    assign o_m_tlast  = r_out_done;

    always_comb begin
        case ({r_which, r_term})
            2'b00: begin
                n_s1 = u_c + u_s; n_t1 = u_c + u_s; n_d1 = u_c - u_s;
                n_s2 = u_n + u_c; n_t2 = u_n + u_c; n_d2 = u_n - u_c;
                n_inv = {33'd0, r_inv_dx};
            end
            2'b01: begin
                n_s1 = v_c + v_s;  n_t1 = u_c + u_e; n_d1 = u_c - u_e;
                n_s2 = v_w + v_sw; n_t2 = u_w + u_c; n_d2 = u_w - u_c;
                n_inv = {33'd0, r_inv_dy};
            end
            2'b10: begin
                n_s1 = u_c + u_e;  n_t1 = v_c + v_s; n_d1 = v_c - v_s;
                n_s2 = u_n + u_ne; n_t2 = v_n + v_c; n_d2 = v_n - v_c;
                n_inv = {33'd0, r_inv_dx};
            end
            default: begin
                n_s1 = v_c + v_e; n_t1 = v_c + v_e; n_d1 = v_c - v_e;
                n_s2 = v_w + v_c; n_t2 = v_w + v_c; n_d2 = v_w - v_c;
                n_inv = {33'd0, r_inv_dy};
            end
        endcase
    end

    always_comb begin
        op_a   = '0;
        op_b   = '0;
        mul_en = 1'b0;
        case (r_state)
            S_IXX: begin
                op_a = {33'd0, r_inv_dx}; op_b = {33'd0, r_inv_dx}; mul_en = !r_ph;
            end
            S_IYY: begin
                op_a = {33'd0, r_inv_dy}; op_b = {33'd0, r_inv_dy}; mul_en = !r_ph;
            end
            S_LAPX: begin
                op_a = r_which ? (v_s - (v_c <<< 1) + v_n) : (u_s - (u_c <<< 1) + u_n);
                op_b = r_ixx; mul_en = !r_ph;
            end
            S_LAPY: begin
                op_a = r_which ? (v_e - (v_c <<< 1) + v_w) : (u_e - (u_c <<< 1) + u_w);
                op_b = r_iyy; mul_en = !r_ph;
            end
            S_LAPR: begin
                op_a = r_lap; op_b = {33'd0, r_inv_re}; mul_en = !r_ph;
            end
            S_CONV: begin
                mul_en = !r_ph;
                case (r_sub)
                    3'd0: begin op_a = r_s1; op_b = r_t1; end
                    3'd1: begin op_a = r_s2; op_b = r_t2; end
                    3'd2: begin op_a = (r_s1 < 0) ? -r_s1 : r_s1; op_b = r_d1; end
                    3'd3: begin op_a = (r_s2 < 0) ? -r_s2 : r_s2; op_b = r_d2; end
                    3'd4: begin op_a = {47'd0, r_alpha}; op_b = r_tmp; end
                    default: begin op_a = r_acc; op_b = r_inv; end
                endcase
            end
            S_FIN: begin
                op_a = {33'd0, r_dt}; op_b = r_sum; mul_en = !r_ph;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    dcms_mulq u_mulq (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (op_a),
        .i_b    (op_b),
        .o_prod (prod)
    );

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_rd1 <= mem_row1[r_col];
            r_rd2 <= mem_row2[r_col];
        end
        if (r_state == S_READ) begin
            mem_row1[r_col] <= {r_v_in, r_u_in};
            mem_row2[r_col] <= r_rd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt     <= 31'd65536;
            r_alpha  <= 17'd58982;
            r_inv_dx <= 31'd65536;
            r_inv_dy <= 31'd65536;
            r_inv_re <= 31'd655;
            r_gx     <= '0;
            r_gy     <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_DT:     r_dt     <= i_cfg_data[30:0];
                REG_ALPHA:  r_alpha  <= i_cfg_data[16:0];
                REG_INV_DX: r_inv_dx <= i_cfg_data[30:0];
                REG_INV_DY: r_inv_dy <= i_cfg_data[30:0];
                REG_INV_RE: r_inv_re <= i_cfg_data[30:0];
                REG_GX:     r_gx     <= i_cfg_data;
                REG_GY:     r_gy     <= i_cfg_data;
                default:    r_dt     <= r_dt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ph        <= 1'b0;
            r_which     <= 1'b0;
            r_term      <= 1'b0;
            r_sub       <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
            r_wl_u1     <= '0;
            r_wl_v1     <= '0;
            r_wl_v2     <= '0;
            for (int k = 0; k < 3; k++) begin
                r_wc_u[k] <= '0;
                r_wc_v[k] <= '0;
            end
        end else begin
            if (r_out_valid && i_m_tready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_u_in  <= i_s_tdata[31:0];
                        r_v_in  <= i_s_tdata[63:32];
                        r_eor   <= i_s_tlast;
                        r_last  <= i_s_tuser;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_f_ok     <= (r_col >= COL_W'(2));
                    r_g_ok     <= (r_row >= ROW_W'(2));
                    r_row_edge <= (r_row == ROW_W'(1)) || r_last;
                    r_col_edge <= (r_col == COL_W'(1)) || r_eor;
                    r_done     <= r_eor && r_last;
                    if (r_eor) begin
                        r_col <= '0;
                        if (r_last) begin
                            r_row <= '0;
                        end else if (r_row != ROW_LAST) begin
                            r_row <= r_row + 1'b1;
                        end
                    end else if (r_col != COL_LAST) begin
                        r_col <= r_col + 1'b1;
                    end
                    if (r_row != '0 && r_col != '0) begin
                        r_ph    <= 1'b0;
                        r_state <= S_IXX;
                    end else begin
                        r_wl_u1   <= r_wc_u[1];
                        r_wl_v1   <= r_wc_v[1];
                        r_wl_v2   <= r_wc_v[2];
                        r_wc_u[0] <= r_rd2[31:0];
                        r_wc_u[1] <= r_rd1[31:0];
                        r_wc_u[2] <= r_u_in;
                        r_wc_v[0] <= r_rd2[63:32];
                        r_wc_v[1] <= r_rd1[63:32];
                        r_wc_v[2] <= r_v_in;
                        r_state   <= S_IDLE;
                    end
                end
                S_IXX: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        r_ixx   <= q;
                        r_state <= S_IYY;
                    end
                end
                S_IYY: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        r_iyy   <= q;
                        r_which <= 1'b0;
                        r_state <= S_PART;
                    end
                end
                S_PART: begin
                    r_ph   <= 1'b0;
                    r_term <= 1'b0;
                    if (!(r_which ? r_g_ok : r_f_ok)) begin
                        if (r_which) begin
                            r_g     <= '0;
                            r_state <= S_EMIT;
                        end else begin
                            r_f     <= '0;
                            r_which <= 1'b1;
                        end
                    end else if (r_which ? r_col_edge : r_row_edge) begin
                        r_sum   <= g_sel;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_LAPX;
                    end
                end
                S_LAPX: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        r_lap   <= q;
                        r_state <= S_LAPY;
                    end
                end
                S_LAPY: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        r_lap   <= r_lap + q;
                        r_state <= S_LAPR;
                    end
                end
                S_LAPR: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        r_sum   <= q + g_sel;
                        r_state <= S_TERM;
                    end
                end
                S_TERM: begin
                    r_s1    <= n_s1;
                    r_t1    <= n_t1;
                    r_d1    <= n_d1;
                    r_s2    <= n_s2;
                    r_t2    <= n_t2;
                    r_d2    <= n_d2;
                    r_inv   <= n_inv;
                    r_sub   <= '0;
                    r_ph    <= 1'b0;
                    r_state <= S_CONV;
                end
                S_CONV: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        r_sub <= r_sub + 1'b1;
                        case (r_sub)
                            3'd0: r_acc <= q;
                            3'd1: r_acc <= r_acc - q;
                            3'd2: r_tmp <= q;
                            3'd3: r_tmp <= r_tmp - q;
                            3'd4: r_acc <= r_acc + q;
                            default: begin
                                r_sum <= r_sum - (q >>> 2);
                                if (r_term) begin
                                    r_state <= S_FIN;
                                end else begin
                                    r_term  <= 1'b1;
                                    r_state <= S_TERM;
                                end
                            end
                        endcase
                    end
                end
                S_FIN: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        if (r_which) begin
                            r_g     <= sat32(c_sel + q);
                            r_state <= S_EMIT;
                        end else begin
                            r_f     <= sat32(c_sel + q);
                            r_which <= 1'b1;
                            r_state <= S_PART;
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_f     <= r_f;
                        r_out_g     <= r_g;
                        r_out_fv    <= r_f_ok;
                        r_out_gv    <= r_g_ok;
                        r_out_done  <= r_done;
                        r_wl_u1     <= r_wc_u[1];
                        r_wl_v1     <= r_wc_v[1];
                        r_wl_v2     <= r_wc_v[2];
                        r_wc_u[0]   <= r_rd2[31:0];
                        r_wc_u[1]   <= r_rd1[31:0];
                        r_wc_u[2]   <= r_u_in;
                        r_wc_v[0]   <= r_rd2[63:32];
                        r_wc_v[1]   <= r_rd1[63:32];
                        r_wc_v[2]   <= r_v_in;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench of the donor-cell F/G momentum stencil with a built-in predictor.
module tb
    import dcms_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] u;
        logic [31:0] v;
        logic        eor;
        logic        last;
    } t_cell;

    typedef struct {
        logic [31:0] f;
        logic        fv;
        logic [31:0] g;
        logic        gv;
        logic        done;
    } t_fg;

    localparam int HOLD_CYCLES = 300;
    localparam int DOG_LIMIT   = 3000;
    localparam int SETTLE      = 100;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_s_tvalid = 1'b0;
    logic             o_s_tready;
    logic [63:0]      i_s_tdata = '0;
    logic             i_s_tlast = 1'b0;
    logic             i_s_tuser = 1'b0;
    logic             o_m_tvalid;
    logic             i_m_tready = 1'b0;
    logic [63:0]      o_m_tdata;
    logic             o_m_tlast;
    logic [1:0]       o_m_tuser;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_index = '0;
    logic [31:0]      i_cfg_data = '0;

    donor_cell_momentum_stencil dut (.*);

    always #5 i_clk = ~i_clk;

    t_cell  cell_q[$];
    t_fg    fg_q[$];
    int     errs = 0;
    int     pushed = 0;
    bit     jitter = 1'b0;
    bit     hold_req = 1'b0;
    int     src_gap = 0;
    int     snk_gap = 0;
    int     hold_cnt = 0;
    int     dog = 0;

    longint dt_q = 65536, alpha_q = 58982, inv_dx_q = 65536, inv_dy_q = 65536;
    longint inv_re_q = 655, gx_q = 0, gy_q = 0;
    longint u_line[2*MAX_COLS];
    longint v_line[2*MAX_COLS];
    longint win[12];
    int     col_cnt = 0;
    int     row_cnt = 0;

    initial begin
        foreach (u_line[k]) begin
            u_line[k] = 0;
            v_line[k] = 0;
        end
        foreach (win[k]) win[k] = 0;
    end

    function automatic longint clamp32(longint x);
        if (x > SAT_HI) return SAT_HI;
        if (x < SAT_LO) return SAT_LO;
        return x;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return (clamp32(a) * clamp32(b)) >>> 16;
    endfunction

    function automatic longint mag(longint x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic longint upwind(longint s1, longint t1, longint d1,
                                      longint s2, longint t2, longint d2, longint inv);
        longint num;
        num = qmul(s1, t1) - qmul(s2, t2)
            + qmul(alpha_q, qmul(mag(s1), d1) - qmul(mag(s2), d2));
        return qmul(num, inv) >>> 2;
    endfunction

    task automatic advance_stencil(input logic [31:0] ui, input logic [31:0] vi,
                                   input logic eor, input logic last);
        longint u[3][3], v[3][3];
        longint uC, uN, uS, uW, uE, uNE, vC, vN, vS, vW, vE, vSW;
        longint ixx, iyy, lap, da, db, f, g;
        int     c;
        t_fg    e;
        c = col_cnt;
        for (int r = 0; r < 3; r++) begin
            u[r][0] = win[r*2];
            u[r][1] = win[r*2+1];
            v[r][0] = win[6+r*2];
            v[r][1] = win[6+r*2+1];
        end
        u[0][2] = u_line[MAX_COLS+c];
        u[1][2] = u_line[c];
        v[0][2] = v_line[MAX_COLS+c];
        v[1][2] = v_line[c];
        u[2][2] = $signed(ui);
        v[2][2] = $signed(vi);
        u_line[MAX_COLS+c] = u[1][2];
        u_line[c] = u[2][2];
        v_line[MAX_COLS+c] = v[1][2];
        v_line[c] = v[2][2];
        for (int r = 0; r < 3; r++) begin
            win[r*2] = u[r][1];
            win[r*2+1] = u[r][2];
            win[6+r*2] = v[r][1];
            win[6+r*2+1] = v[r][2];
        end
        if (row_cnt >= 1 && col_cnt >= 1) begin
            uC = u[1][1]; uN = u[0][1]; uS = u[2][1]; uW = u[1][0]; uE = u[1][2];
            uNE = u[0][2];
            vC = v[1][1]; vN = v[0][1]; vS = v[2][1]; vW = v[1][0]; vE = v[1][2];
            vSW = v[2][0];
            ixx = qmul(inv_dx_q, inv_dx_q);
            iyy = qmul(inv_dy_q, inv_dy_q);
            f = 0;
            g = 0;
            e.fv = (col_cnt >= 2);
            e.gv = (row_cnt >= 2);
            if (e.fv) begin
                if (row_cnt == 1 || last) begin
                    f = clamp32(uC + qmul(dt_q, gx_q));
                end else begin
                    lap = qmul(uS - 2*uC + uN, ixx) + qmul(uE - 2*uC + uW, iyy);
                    da = upwind(uC + uS, uC + uS, uC - uS, uN + uC, uN + uC, uN - uC, inv_dx_q);
                    db = upwind(vC + vS, uC + uE, uC - uE, vW + vSW, uW + uC, uW - uC, inv_dy_q);
                    f = clamp32(uC + qmul(dt_q, qmul(lap, inv_re_q) - da - db + gx_q));
                end
            end
            if (e.gv) begin
                if (col_cnt == 1 || eor) begin
                    g = clamp32(vC + qmul(dt_q, gy_q));
                end else begin
                    lap = qmul(vS - 2*vC + vN, ixx) + qmul(vE - 2*vC + vW, iyy);
                    da = upwind(uC + uE, vC + vS, vC - vS, uN + uNE, vN + vC, vN - vC, inv_dx_q);
                    db = upwind(vC + vE, vC + vE, vC - vE, vW + vC, vW + vC, vW - vC, inv_dy_q);
                    g = clamp32(vC + qmul(dt_q, qmul(lap, inv_re_q) - da - db + gy_q));
                end
            end
            e.f = f[31:0];
            e.g = g[31:0];
            e.done = eor && last;
            fg_q.push_back(e);
        end
        if (eor) begin
            col_cnt = 0;
            if (last) begin
                row_cnt = 0;
            end else if (row_cnt < 2047) begin
                row_cnt++;
            end
        end else if (col_cnt < MAX_COLS - 1) begin
            col_cnt++;
        end
    endtask

    // Input side: the current word is retired on acceptance, then the next one is offered.
    always @(posedge i_clk) begin
        t_cell it;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                advance_stencil(i_s_tdata[31:0], i_s_tdata[63:32], i_s_tlast, i_s_tuser);
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (cell_q.size() > 0) begin
                    if (jitter && $urandom_range(0, 7) == 0) begin
                        src_gap = $urandom_range(0, 8);
                        i_s_tvalid <= 1'b0;
                    end else begin
                        it = cell_q.pop_front();
                        i_s_tdata <= {it.v, it.u};
                        i_s_tlast <= it.eor;
                        i_s_tuser <= it.last;
                        i_s_tvalid <= 1'b1;
                    end
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output side: each accepted word is checked against the oldest expected F/G pair.
    always @(posedge i_clk) begin
        t_fg e;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (fg_q.size() == 0) begin
                    $error("unexpected word: tdata %h tuser %b tlast %b",
                           o_m_tdata, o_m_tuser, o_m_tlast);
                    errs++;
                end else begin
                    e = fg_q.pop_front();
                    if (o_m_tdata[31:0] !== e.f) begin
                        $error("f_value: expected %h, got %h", e.f, o_m_tdata[31:0]);
                        errs++;
                    end
                    if (o_m_tuser[0] !== e.fv) begin
                        $error("f_valid: expected %b, got %b", e.fv, o_m_tuser[0]);
                        errs++;
                    end
                    if (o_m_tdata[63:32] !== e.g) begin
                        $error("g_value: expected %h, got %h", e.g, o_m_tdata[63:32]);
                        errs++;
                    end
                    if (o_m_tuser[1] !== e.gv) begin
                        $error("g_valid: expected %b, got %b", e.gv, o_m_tuser[1]);
                        errs++;
                    end
                    if (o_m_tlast !== e.done) begin
                        $error("frame_done: expected %b, got %b", e.done, o_m_tlast);
                        errs++;
                    end
                end
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_m_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_cnt = HOLD_CYCLES;
                i_m_tready <= 1'b0;
            end else if (snk_gap > 0) begin
                snk_gap--;
                i_m_tready <= 1'b0;
            end else if (jitter && $urandom_range(0, 7) == 0) begin
                snk_gap = $urandom_range(0, 8);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            dog <= 0;
        end else if (dog >= DOG_LIMIT) begin
            $display("tb failed");
            $finish;
        end else begin
            dog <= dog + 1;
        end
    end

    function automatic logic [31:0] pick_velocity(int mode, int n);
        logic [31:0] ext[6];
        ext = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h5555_AAAA};
        if (mode == 1) return ext[n % 6];
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return $urandom;
            default: return $urandom_range(0, 1 << 19) - (1 << 18);
        endcase
    endfunction

    task automatic push_frame(int imax, int jmax, int mode);
        t_cell it;
        for (int r = 0; r <= imax + 1; r++) begin
            for (int c = 0; c <= jmax + 1; c++) begin
                it.u = pick_velocity(mode, pushed);
                it.v = pick_velocity(mode, pushed + 3);
                it.eor = (c == jmax + 1);
                it.last = (r == imax + 1)
                    || (mode == 0 && c != jmax + 1 && $urandom_range(0, 24) == 0);
                cell_q.push_back(it);
                pushed++;
            end
        end
    endtask

    task automatic drain();
        while (cell_q.size() != 0 || i_s_tvalid || fg_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_reg(t_cfg_reg idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_DT:     dt_q = val[30:0];
            REG_ALPHA:  alpha_q = val[16:0];
            REG_INV_DX: inv_dx_q = val[30:0];
            REG_INV_DY: inv_dy_q = val[30:0];
            REG_INV_RE: inv_re_q = val[30:0];
            REG_GX:     gx_q = $signed(val);
            REG_GY:     gy_q = $signed(val);
            default: ;
        endcase
    endtask

    task automatic apply_setting(int kind);
        logic [31:0] r[7];
        case (kind)
            1: r = '{32'h7FFF_FFFF, 32'd65536, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h7FFF_FFFF};
            2: r = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
            3: r = '{$urandom_range(0, 32'h0003_0000), $urandom_range(0, 65536),
                     $urandom_range(0, 32'h0004_0000), $urandom_range(0, 32'h0004_0000),
                     $urandom_range(0, 32'h0000_4000), $urandom, $urandom};
            4: r = '{32'h0000_1000, 32'd32768, 32'h0002_0000, 32'h0000_8000, 32'd655,
                     32'h0001_0000, 32'hFFFF_0000};
            default: r = '{32'd65536, 32'd58982, 32'd65536, 32'd65536, 32'd655, 32'h0, 32'h0};
        endcase
        set_reg(REG_DT, r[0]);
        set_reg(REG_ALPHA, r[1]);
        set_reg(REG_INV_DX, r[2]);
        set_reg(REG_INV_DY, r[3]);
        set_reg(REG_INV_RE, r[4]);
        set_reg(REG_GX, r[5]);
        set_reg(REG_GY, r[6]);
    endtask

    initial begin
        int kinds[6];
        int goal;
        kinds = '{4, 1, 2, 3, 0, 3};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        push_frame(2, 2, 1);
        drain();
        for (int p = 0; p < 6; p++) begin
            apply_setting(kinds[p]);
            jitter = (p != 5) && (p != 2);
            if (p == 1) hold_req = 1'b1;
            goal = pushed + 80;
            while (pushed < goal) push_frame($urandom_range(0, 6), $urandom_range(0, 8), 0);
            drain();
        end
        if (errs == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
